[hw/rtl/rcr_pkg.sv]
// ----------------------------------------------------------------------------
// rcr_pkg: shared types and codes for the recovery confirm/reset controller
// Mode, status, event and register codes plus the configuration, state, event
// and result structs passed between the top level and the step logic.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rcr_pkg;

  typedef enum logic [1:0] {
    MODE_NORMAL       = 2'd0,
    MODE_WAIT_CONFIRM = 2'd1,
    MODE_RESET_WAIT   = 2'd2,
    MODE_EXECUTING    = 2'd3
  } mode_t;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_ARG   = 2'd1;
  localparam logic [1:0] ST_STATE = 2'd2;

  localparam logic [2:0] RT_CONTROL    = 3'd0;
  localparam logic [2:0] RT_DISCONNECT = 3'd1;
  localparam logic [2:0] RT_REPLY_SENT = 3'd2;
  localparam logic [2:0] RT_TICK       = 3'd3;
  localparam logic [2:0] RT_GESTURE    = 3'd4;

  localparam logic [3:0] ACT_PING       = 4'd0;
  localparam logic [3:0] ACT_REQUEST    = 4'd1;
  localparam logic [3:0] ACT_CONFIRM    = 4'd2;
  localparam logic [3:0] ACT_DISCONNECT = 4'd3;

  localparam logic [1:0] REG_CONFIRM_TOKEN  = 2'd0;
  localparam logic [1:0] REG_CONFIRM_WINDOW = 2'd1;
  localparam logic [1:0] REG_REPLY_DELAY    = 2'd2;

  localparam logic [31:0] CONFIRM_TOKEN_RST  = 32'd0;
  localparam logic [19:0] CONFIRM_WINDOW_RST = 20'd30000;
  localparam logic [15:0] REPLY_DELAY_RST    = 16'd1500;

  typedef struct packed {
    logic [31:0] confirm_token;
    logic [19:0] confirm_window_ms;
    logic [15:0] reply_delay_ms;
  } cfg_t;

  typedef struct packed {
    mode_t       mode;
    logic [31:0] request_time;
    logic [31:0] reply_seq;
    logic        reply_flag;
    logic [31:0] reply_time;
    logic        local_flag;
  } state_t;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [3:0]  action;
    logic [31:0] token;
    logic [31:0] sequence_req;
    logic [31:0] now_ms;
    logic        drained;
  } evt_t;

  typedef struct packed {
    logic [1:0] status;
    mode_t      mode_now;
    logic       reset_issue;
    logic       runtime_requested;
  } res_t;

endpackage

[hw/rtl/rcr_step.sv]
// ----------------------------------------------------------------------------
// rcr_step: one-event state update
// Combinational next state and result for one event against the current
// state and configuration.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rcr_step (
  input  rcr_pkg::cfg_t   cfg,
  input  rcr_pkg::state_t st,
  input  rcr_pkg::evt_t   evt,
  output rcr_pkg::state_t st_nxt,
  output rcr_pkg::res_t   res
);

  logic [31:0] req_age;
  logic [31:0] reply_age;
  logic [31:0] delay_ext;
  logic        tok_ok;
  logic        disc_take;
  logic [1:0]  status;
  logic        issue;

  assign delay_ext = {16'd0, cfg.reply_delay_ms};
  assign req_age   = evt.now_ms - st.request_time;
  assign reply_age = evt.now_ms - st.reply_time;
  assign disc_take = !st.local_flag && (st.mode != rcr_pkg::MODE_EXECUTING);

  // ping and disconnect carry a zero token, request and confirm the programmed one
  assign tok_ok = (evt.action == rcr_pkg::ACT_PING || evt.action == rcr_pkg::ACT_DISCONNECT)
                  ? (evt.token == 32'd0) : (evt.token == cfg.confirm_token);

  always_comb begin
    st_nxt = st;
    status = rcr_pkg::ST_OK;
    issue  = 1'b0;
    case (evt.req_type)
      rcr_pkg::RT_CONTROL: begin
        if (evt.action > rcr_pkg::ACT_DISCONNECT) begin
          status = rcr_pkg::ST_ARG;
        end else if (!tok_ok) begin
          status = rcr_pkg::ST_ARG;
        end else begin
          unique case (evt.action)
            rcr_pkg::ACT_PING: ;
            rcr_pkg::ACT_DISCONNECT: begin
              if (disc_take) begin
                st_nxt.mode       = rcr_pkg::MODE_NORMAL;
                st_nxt.reply_flag = 1'b0;
              end
            end
            rcr_pkg::ACT_REQUEST: begin
              if (st.mode == rcr_pkg::MODE_RESET_WAIT || st.mode == rcr_pkg::MODE_EXECUTING) begin
                status = rcr_pkg::ST_STATE;
              end else begin
                st_nxt.request_time = evt.now_ms;
                st_nxt.mode         = rcr_pkg::MODE_WAIT_CONFIRM;
              end
            end
            default: begin
              // confirm
              if (st.mode != rcr_pkg::MODE_WAIT_CONFIRM ||
                  req_age > {12'd0, cfg.confirm_window_ms}) begin
                status = rcr_pkg::ST_STATE;
              end else begin
                st_nxt.reply_seq  = evt.sequence_req;
                st_nxt.reply_flag = 1'b0;
                st_nxt.mode       = rcr_pkg::MODE_RESET_WAIT;
              end
            end
          endcase
        end
      end
      rcr_pkg::RT_DISCONNECT: begin
        if (disc_take) begin
          st_nxt.mode       = rcr_pkg::MODE_NORMAL;
          st_nxt.reply_flag = 1'b0;
        end
      end
      rcr_pkg::RT_REPLY_SENT: begin
        if (st.mode == rcr_pkg::MODE_RESET_WAIT && evt.sequence_req == st.reply_seq) begin
          st_nxt.reply_time = evt.now_ms;
          st_nxt.reply_flag = 1'b1;
        end
      end
      rcr_pkg::RT_TICK: begin
        if (evt.drained && st.reply_flag && reply_age >= delay_ext &&
            st.mode == rcr_pkg::MODE_RESET_WAIT) begin
          st_nxt.mode = rcr_pkg::MODE_EXECUTING;
          issue       = 1'b1;
        end
      end
      rcr_pkg::RT_GESTURE: begin
        // local arm: delay counts as already elapsed
        if (!st.local_flag) begin
          st_nxt.local_flag = 1'b1;
          st_nxt.reply_time = evt.now_ms - delay_ext;
          st_nxt.reply_flag = 1'b1;
          st_nxt.mode       = rcr_pkg::MODE_RESET_WAIT;
        end
      end
      default: ;
    endcase
  end

  assign res.status            = status;
  assign res.mode_now          = st_nxt.mode;
  assign res.reset_issue       = issue;
  assign res.runtime_requested = (st_nxt.mode == rcr_pkg::MODE_RESET_WAIT) ||
                                 (st_nxt.mode == rcr_pkg::MODE_EXECUTING);

endmodule

[hw/rtl/recovery_confirm_reset_fsm.sv]
// ----------------------------------------------------------------------------
// recovery_confirm_reset_fsm: recovery confirm/reset handshake controller
// Takes one event per request (control command, disconnect, reply sent,
// process tick, local gesture) and returns one result per event with the
// command status, the mode after the event, a one-shot reset_issue flag and runtime_requested.
// Events are accepted every cycle while the result channel is not stalled; each
// result passes through the input register, then the combinational state update
// into the result register, and a stalled result still lets one more request in.
// Times are 32-bit wrapping milliseconds; registers are written on cfg_wr_en.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module recovery_confirm_reset_fsm (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // [3:0] action, [35:4] token, [67:36] sequence_req, [99:68] now_ms,
  // [100] drained, [103:101] zero
  input  logic [103:0] in_tdata,
  // [2:0] req_type
  input  logic [2:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // [1:0] status, [3:2] mode_now, [4] reset_issue, [5] runtime_requested,
  // [7:6] zero
  output logic [7:0]   out_tdata,
  input  logic         cfg_wr_en,
  input  logic [1:0]   cfg_index,
  input  logic [31:0]  cfg_wdata
);

  rcr_pkg::cfg_t   cfg_r;
  rcr_pkg::state_t st_r;
  rcr_pkg::state_t st_nxt;
  rcr_pkg::evt_t   evt_r;
  rcr_pkg::evt_t   evt_in;
  rcr_pkg::res_t   res_nxt;
  rcr_pkg::res_t   res_r;
  logic            s1_valid_r;
  logic            out_valid_r;
  logic            adv;

  assign evt_in.req_type     = in_tuser;
  assign evt_in.action       = in_tdata[3:0];
  assign evt_in.token        = in_tdata[35:4];
  assign evt_in.sequence_req = in_tdata[67:36];
  assign evt_in.now_ms       = in_tdata[99:68];
  assign evt_in.drained      = in_tdata[100];

  // stage 1 moves on when the result register is free or being emptied
  assign adv       = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || adv;

  rcr_step u_step (
    .cfg    (cfg_r),
    .st     (st_r),
    .evt    (evt_r),
    .st_nxt (st_nxt),
    .res    (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.confirm_token     <= rcr_pkg::CONFIRM_TOKEN_RST;
      cfg_r.confirm_window_ms <= rcr_pkg::CONFIRM_WINDOW_RST;
      cfg_r.reply_delay_ms    <= rcr_pkg::REPLY_DELAY_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        rcr_pkg::REG_CONFIRM_TOKEN:  cfg_r.confirm_token     <= cfg_wdata;
        rcr_pkg::REG_CONFIRM_WINDOW: cfg_r.confirm_window_ms <= cfg_wdata[19:0];
        rcr_pkg::REG_REPLY_DELAY:    cfg_r.reply_delay_ms    <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.mode         <= rcr_pkg::MODE_NORMAL;
      st_r.request_time <= 32'd0;
      st_r.reply_seq    <= 32'd0;
      st_r.reply_flag   <= 1'b0;
      st_r.reply_time   <= 32'd0;
      st_r.local_flag   <= 1'b0;
      s1_valid_r        <= 1'b0;
      out_valid_r       <= 1'b0;
    end else begin
      if (adv) begin
        st_r <= st_nxt;
      end
      if (in_tvalid && in_tready) begin
        s1_valid_r <= 1'b1;
      end else if (adv) begin
        s1_valid_r <= 1'b0;
      end
      if (adv) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      evt_r <= evt_in;
    end
    if (adv) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, res_r.runtime_requested, res_r.reset_issue,
                       res_r.mode_now, res_r.status};

endmodule

[hw/rtl/rcr_checker.sv]
// ----------------------------------------------------------------------------
// rcr_checker: port-level checks for the recovery confirm/reset controller
// Watches the result channel for consistent mode, status and reset flags.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rcr_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [7:0]   out_tdata
);

  // reset is only issued on entry to executing
  a_issue_exec: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[4] |-> out_tdata[3:2] == rcr_pkg::MODE_EXECUTING)
    else $error("reset_issue without executing mode");

  a_runtime_mode: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[5] == out_tdata[3])
    else $error("runtime_requested does not follow mode");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[1:0] <= rcr_pkg::ST_STATE)
    else $error("undefined status code");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  // input only backs up behind a stalled result
  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("request blocked without a stalled result");

endmodule

bind recovery_confirm_reset_fsm rcr_checker u_rcr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
